FILE: design/ptp_clock_rate_holdover_defines.svh
// shared assertion macros for the clock rate holdover block
`ifndef PTP_CLOCK_RATE_HOLDOVER_DEFINES_SVH
`define PTP_CLOCK_RATE_HOLDOVER_DEFINES_SVH

// checked on every edge out of reset
`define CRH_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define CRH_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: design/ptp_crh_pkg.sv
package ptp_crh_pkg;

    localparam int unsigned DIV_W   = 64;
    localparam int unsigned STEP_W  = 7;
    localparam logic [23:0] TICKS_PER_SECOND = 24'd10000000;
    localparam logic [15:0] SYNC_PERIOD_RESET = 16'd10;
    localparam logic [47:0] MIN_SECONDS_RESET = 48'd1608336000;

    // floor(x / 100) as (x * NS_DIV100_MUL) >> NS_DIV100_SHIFT, exact below 2^32
    localparam logic [30:0] NS_DIV100_MUL   = 31'h51EB_851F;
    localparam int unsigned NS_DIV100_SHIFT = 37;

    // register indexes
    localparam logic CFG_SYNC_PERIOD = 1'b0;
    localparam logic CFG_MIN_SECONDS = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_NS_WAIT,
        ST_CHECK,
        ST_RATIO_WAIT,
        ST_EVAL,
        ST_SYNC,
        ST_COMMIT,
        ST_HOLD_MUL_LO,
        ST_HOLD_MUL_HI,
        ST_HOLD_DIV,
        ST_HOLD_WAIT,
        ST_HOLD_END,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              start;
        logic [STEP_W-1:0] steps;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

FILE: design/ptp_clock_rate_holdover.sv
// channel   dir  handshake                  payload
// s         in   i_s_tvalid / o_s_tready    time query word (local time, ptp capture)
// m         out  o_m_tvalid / i_m_tready    corrected time, rate factor, precision
// cfg       in   i_cfg_valid / o_cfg_ready  register index and write data
//
// the serial divider works FACTOR_FRAC_BITS steps for the rate ratio of a query
// with a valid capture, 64 steps for the holdover term of a holdover query with
// correction; a holdover query without correction does not use it
// one query is worked at a time; o_s_tready is high only while idle
// the finished word waits in the output register, a stalled m side holds it
// synchronous active-low reset restores rate factor 1.0 and the register defaults

`include "ptp_clock_rate_holdover_defines.svh"

module ptp_clock_rate_holdover #(
    parameter int unsigned FACTOR_FRAC_BITS = 30
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // [62:0] local_time_100ns, [110:63] ptp_seconds, [140:111] ptp_nanoseconds
    input  logic [143:0] i_s_tdata,
    // [0] ptp_capture_ok
    input  logic [0:0]   i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [63:0] corrected_time_100ns, [94:64] rate_factor_out, [110:95] precision_out
    output logic [111:0] o_m_tdata,
    // [0] sample_valid
    output logic [0:0]   o_m_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [0:0]   i_cfg_index,
    input  logic [47:0]  i_cfg_data
);
    import ptp_crh_pkg::*;

    localparam int unsigned FW = FACTOR_FRAC_BITS + 1;
    localparam logic [FW-1:0] FX_ONE = FW'(1) << FACTOR_FRAC_BITS;
    localparam logic [FW-1:0] FX_RANGE =
        FW'(((64'd1 << FACTOR_FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [62:0] LOCAL_MAX = '1;
    localparam logic [63:0] PTP_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    // configuration
    logic [15:0] r_sync_per;
    logic [47:0] r_min_sec;

    // sequencer and item
    t_state r_state, n_state;
    logic [62:0] r_local;
    logic [47:0] r_psec;
    logic [29:0] r_pns;
    logic [63:0] r_acc, n_acc;
    logic [63:0] r_ptp, n_ptp;
    logic [63:0] r_dptp, n_dptp;
    logic        r_q, n_q;
    logic [56:0] r_limit, n_limit;
    logic [FW-1:0] r_f, n_f;
    logic [50:0] r_pmul, n_pmul;
    logic        r_inval, n_inval;
    logic [63:0] r_res, n_res;
    logic [62:0] r_delta, n_delta;
    logic [FW-1:0] r_m, n_m;
    logic        r_sub, n_sub;
    logic [95:0] r_prod, n_prod;

    // block state
    logic        r_win_open, n_win_open;
    logic [62:0] r_win_local, n_win_local;
    logic [63:0] r_win_ptp, n_win_ptp;
    logic [31:0] r_next_sync, n_next_sync;
    logic [63:0] r_offset, n_offset;
    logic [62:0] r_last_local, n_last_local;
    logic        r_synced, n_synced;
    logic [FW-1:0] r_rate, n_rate;
    logic [15:0] r_prec, n_prec;

    // output register
    logic         r_m_tvalid, n_m_tvalid;
    logic [111:0] r_m_tdata, n_m_tdata;
    logic         r_m_tuser, n_m_tuser;

    // shared divider
    t_div_ctl    div_ctl;
    t_div_sts    div_sts;
    logic [63:0] div_rem0, div_dvd, div_den, div_quot;

    ptp_crh_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (div_ctl),
        .i_rem0 (div_rem0),
        .i_dvd  (div_dvd),
        .i_den  (div_den),
        .o_sts  (div_sts),
        .o_quot (div_quot)
    );

    // input word fields
    logic [62:0] in_local;
    logic [47:0] in_psec;
    logic [29:0] in_pns;
    logic        in_accept;

    assign in_local  = i_s_tdata[62:0];
    assign in_psec   = i_s_tdata[110:63];
    assign in_pns    = i_s_tdata[140:111];
    assign in_accept = i_s_tvalid && o_s_tready;

    assign o_s_tready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_tvalid;
    assign o_m_tdata   = r_m_tdata;
    assign o_m_tuser   = r_m_tuser;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_per <= SYNC_PERIOD_RESET;
            r_min_sec  <= MIN_SECONDS_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SYNC_PERIOD: r_sync_per <= i_cfg_data[15:0];
                CFG_MIN_SECONDS: r_min_sec  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // combinational scratch
    logic [47:0] mul_lo, mul_hi;
    logic [61:0] ns_prod;
    logic [63:0] dptp_c;
    logic [62:0] dloc_c;
    logic [32:0] lim_sum;
    logic [FW-1:0] dev_c, dfac_c;
    logic [50:0] prec_s;
    logic [62:0] hold_delta;
    logic [62:0] plo;
    logic [61:0] phi;

    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_ptp        = r_ptp;
        n_dptp       = r_dptp;
        n_q          = r_q;
        n_limit      = r_limit;
        n_f          = r_f;
        n_pmul       = r_pmul;
        n_inval      = r_inval;
        n_res        = r_res;
        n_delta      = r_delta;
        n_m          = r_m;
        n_sub        = r_sub;
        n_prod       = r_prod;
        n_win_open   = r_win_open;
        n_win_local  = r_win_local;
        n_win_ptp    = r_win_ptp;
        n_next_sync  = r_next_sync;
        n_offset     = r_offset;
        n_last_local = r_last_local;
        n_synced     = r_synced;
        n_rate       = r_rate;
        n_prec       = r_prec;
        n_m_tvalid   = r_m_tvalid && !i_m_tready;
        n_m_tdata    = r_m_tdata;
        n_m_tuser    = r_m_tuser;

        div_ctl.start = 1'b0;
        div_ctl.steps = '0;
        div_rem0      = '0;
        div_dvd       = '0;
        div_den       = '0;

        mul_lo     = 48'(r_psec[23:0]) * 48'(TICKS_PER_SECOND);
        mul_hi     = 48'(r_psec[47:24]) * 48'(TICKS_PER_SECOND);
        ns_prod    = 62'(r_pns) * 62'(NS_DIV100_MUL);
        dptp_c     = r_ptp - r_win_ptp;
        dloc_c     = r_local - r_win_local;
        lim_sum    = 33'(r_sync_per) + 33'(r_next_sync);
        dev_c      = (r_f >= FX_ONE) ? (r_f - FX_ONE) : (FX_ONE - r_f);
        dfac_c     = (r_f >= r_rate) ? (r_f - r_rate) : (r_rate - r_f);
        prec_s     = r_pmul >> FACTOR_FRAC_BITS;
        hold_delta = r_local - r_last_local;
        plo        = 63'(r_delta[31:0]) * 63'(r_m);
        phi        = 62'(r_delta[62:32]) * 62'(r_m);

        unique case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_state = (i_s_tuser[0] && (in_psec > r_min_sec)) ?
                              ST_MUL_LO : ST_HOLD_MUL_LO;
                end
            end
            // nanoseconds / 100 by reciprocal multiply, then seconds times 10^7 in halves
            ST_MUL_LO: begin
                n_acc   = 64'(ns_prod >> NS_DIV100_SHIFT);
                n_state = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                n_acc   = r_acc + 64'(mul_lo);
                n_state = ST_NS_WAIT;
            end
            ST_NS_WAIT: begin
                n_ptp   = r_acc + 64'({mul_hi, 24'd0});
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_inval = 1'b0;
                n_dptp  = dptp_c;
                n_limit = 57'(lim_sum) * 57'(TICKS_PER_SECOND);
                n_q     = (64'(dloc_c) >= dptp_c);
                if (!r_win_open) begin
                    // first valid capture opens the window
                    n_win_open  = 1'b1;
                    n_win_local = r_local;
                    n_win_ptp   = r_ptp;
                    n_state     = ST_COMMIT;
                end else if (r_ptp <= r_win_ptp || r_local <= r_win_local) begin
                    n_inval = 1'b1;
                    n_state = ST_COMMIT;
                end else if (64'(dloc_c >> 1) >= dptp_c) begin
                    // ratio of two or more
                    n_inval = 1'b1;
                    n_state = ST_COMMIT;
                end else begin
                    div_ctl.start = 1'b1;
                    div_ctl.steps = STEP_W'(FACTOR_FRAC_BITS);
                    div_rem0      = (64'(dloc_c) >= dptp_c) ?
                                    (64'(dloc_c) - dptp_c) : 64'(dloc_c);
                    div_den       = dptp_c;
                    n_state       = ST_RATIO_WAIT;
                end
            end
            ST_RATIO_WAIT: begin
                if (div_sts.done) begin
                    n_f     = {r_q, div_quot[FACTOR_FRAC_BITS-1:0]};
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                n_pmul = 51'(dfac_c) * 51'(327680);
                if (dev_c >= FX_RANGE) begin
                    n_inval = 1'b1;
                    n_state = ST_COMMIT;
                end else if (r_dptp > 64'(r_limit)) begin
                    n_state = ST_SYNC;
                end else begin
                    n_state = ST_COMMIT;
                end
            end
            // accept the factor, precision saturated to q1.15
            ST_SYNC: begin
                if (prec_s == '0) begin
                    n_prec = 16'h7FFF;
                end else if (prec_s > 51'd65536) begin
                    n_prec = 16'h8000;
                end else begin
                    n_prec = 16'(17'd32768 - 17'(prec_s));
                end
                n_next_sync = r_next_sync + 32'(r_sync_per);
                n_rate      = r_f;
                n_state     = ST_COMMIT;
            end
            ST_COMMIT: begin
                if (r_ptp < PTP_MAX && r_local != LOCAL_MAX) begin
                    n_offset = r_ptp - 64'(r_local);
                end
                n_last_local = r_local;
                n_synced     = 1'b1;
                n_res        = r_ptp;
                if (r_inval) begin
                    n_win_open  = 1'b0;
                    n_win_local = '0;
                    n_win_ptp   = '0;
                    n_next_sync = '0;
                    n_prec      = '0;
                end
                n_state = ST_OUT;
            end
            // holdover: local + offset, corrected by delta*(1-f)/f
            ST_HOLD_MUL_LO: begin
                n_inval = 1'b1;
                n_res   = 64'(r_local) + r_offset;
                n_delta = hold_delta;
                n_sub   = (r_rate > FX_ONE);
                n_m     = (r_rate > FX_ONE) ? (r_rate - FX_ONE) : (FX_ONE - r_rate);
                n_state = (r_synced && (r_last_local < r_local)) ?
                          ST_HOLD_MUL_HI : ST_HOLD_END;
            end
            ST_HOLD_MUL_HI: begin
                n_prod  = 96'(plo);
                n_state = ST_HOLD_DIV;
            end
            ST_HOLD_DIV: begin
                n_prod = r_prod + 96'({phi, 32'd0});
                n_state = ST_HOLD_WAIT;
            end
            ST_HOLD_WAIT: begin
                if (!div_sts.busy && !div_sts.done) begin
                    div_ctl.start = 1'b1;
                    div_ctl.steps = STEP_W'(64);
                    div_rem0      = 64'(r_prod[95:64]);
                    div_dvd       = r_prod[63:0];
                    div_den       = 64'(r_rate);
                end else if (div_sts.done) begin
                    n_res   = r_sub ? (r_res - div_quot) : (r_res + div_quot);
                    n_state = ST_HOLD_END;
                end
            end
            ST_HOLD_END: begin
                n_win_open  = 1'b0;
                n_win_local = '0;
                n_win_ptp   = '0;
                n_next_sync = '0;
                n_prec      = '0;
                n_state     = ST_OUT;
            end
            ST_OUT: begin
                if (!r_m_tvalid || i_m_tready) begin
                    n_m_tvalid = 1'b1;
                    n_m_tdata  = {1'b0, r_prec, 31'(r_rate), r_res};
                    n_m_tuser  = !r_inval;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_win_open   <= 1'b0;
            r_win_local  <= '0;
            r_win_ptp    <= '0;
            r_next_sync  <= '0;
            r_offset     <= '0;
            r_last_local <= '0;
            r_synced     <= 1'b0;
            r_rate       <= FX_ONE;
            r_prec       <= '0;
            r_m_tvalid   <= 1'b0;
            r_inval      <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_win_open   <= n_win_open;
            r_win_local  <= n_win_local;
            r_win_ptp    <= n_win_ptp;
            r_next_sync  <= n_next_sync;
            r_offset     <= n_offset;
            r_last_local <= n_last_local;
            r_synced     <= n_synced;
            r_rate       <= n_rate;
            r_prec       <= n_prec;
            r_m_tvalid   <= n_m_tvalid;
            r_inval      <= n_inval;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_local <= in_local;
            r_psec  <= in_psec;
            r_pns   <= in_pns;
        end
        r_acc     <= n_acc;
        r_ptp     <= n_ptp;
        r_dptp    <= n_dptp;
        r_q       <= n_q;
        r_limit   <= n_limit;
        r_f       <= n_f;
        r_pmul    <= n_pmul;
        r_res     <= n_res;
        r_delta   <= n_delta;
        r_m       <= n_m;
        r_sub     <= n_sub;
        r_prod    <= n_prod;
        r_m_tdata <= n_m_tdata;
        r_m_tuser <= n_m_tuser;
    end

    `CRH_ASSERT(a_closed_no_sync, !r_win_open |-> (r_next_sync == '0), "sync count with closed window")
    `CRH_ASSERT(a_prec_needs_window, (r_prec != '0) |-> r_win_open, "precision without open window")
    `CRH_ASSERT(a_rate_in_band, (r_rate > FX_ONE - FX_RANGE) && (r_rate < FX_ONE + FX_RANGE), "rate factor out of band")

endmodule

FILE: design/ptp_crh_div.sv
`include "ptp_clock_rate_holdover_defines.svh"

module ptp_crh_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ptp_crh_pkg::t_div_ctl         i_ctl,
    input  logic [ptp_crh_pkg::DIV_W-1:0] i_rem0,
    input  logic [ptp_crh_pkg::DIV_W-1:0] i_dvd,
    input  logic [ptp_crh_pkg::DIV_W-1:0] i_den,
    output ptp_crh_pkg::t_div_sts         o_sts,
    output logic [ptp_crh_pkg::DIV_W-1:0] o_quot
);
    import ptp_crh_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DIV_W-1:0]  r_rem;
    logic [DIV_W-1:0]  r_dvd;
    logic [DIV_W-1:0]  r_den;
    logic [DIV_W-1:0]  r_quo;

    logic [DIV_W:0] trial;
    logic [DIV_W:0] diff;
    logic           ge;

    // one quotient bit a cycle, restoring
    always_comb begin
        trial = {r_rem, r_dvd[DIV_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_rem0;
            r_dvd <= i_dvd;
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            r_dvd <= {r_dvd[DIV_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_W-2:0], ge};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quot     = r_quo;

    `CRH_ASSERT(a_no_restart, i_ctl.start |-> !r_busy, "divider started while busy")
    `CRH_ASSERT(a_done_after_busy, r_done |-> $past(r_busy), "divider done without work")
    `CRH_ASSERT(a_busy_count, r_busy |-> (r_cnt != '0), "divider busy with no steps left")

endmodule
